@@ hw/rtl/esc_sps_pkg.sv @@
// Shared types and constants for the ESC stick-programming sequencer.
// Holds the transaction structs, the config write struct and the option-count table.
// No dependencies.
package esc_sps_pkg;

	localparam int unsigned ROWS_DEFAULT = 12;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_FULL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT       = 3'd6;

	localparam logic [11:0] STICK_HIGH = 12'd3500;
	localparam logic [11:0] STICK_LOW  = 12'd500;
	localparam logic [11:0] THR_FULL    = 12'd4095;
	localparam logic [11:0] THR_ZERO    = 12'd0;
	localparam logic [11:0] THR_NEUTRAL = 12'd2048;
	localparam logic [11:0] STEER_CENTER = 12'd2048;

	typedef struct packed {
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [31:0] time_ms;
		logic        restart;
	} sample_t;

	typedef struct packed {
		logic [11:0] steer_out;
		logic [11:0] throttle_out;
		logic [3:0]  phase;
		logic [3:0]  edit_row;
		logic [3:0]  edit_option;
		logic [3:0]  prog_row;
		logic        complete;
	} command_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

	function automatic logic [3:0] option_count(input logic [3:0] row);
		logic [3:0] cnt;
		case (row)
			4'd0: cnt = 4'd4;
			4'd1: cnt = 4'd2;
			4'd5: cnt = 4'd8;
			4'd9: cnt = 4'd8;
			4'd10: cnt = 4'd7;
			4'd11: cnt = 4'd6;
			default: cnt = 4'd10;
		endcase
		return cnt;
	endfunction

endpackage

@@ hw/rtl/esc_sps_core.sv @@
// Sequencer state, configuration registers and the per-sample update logic.
// Depends on esc_sps_pkg.
module esc_sps_core #(
	parameter int unsigned ROWS = esc_sps_pkg::ROWS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  esc_sps_pkg::sample_t  smp,
	input  esc_sps_pkg::cfg_wr_t  cfg,
	output esc_sps_pkg::command_t cmd
);
	import esc_sps_pkg::*;

	localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned PrW = $clog2(ROWS + 1);

	typedef enum logic [3:0] {
		PH_EDIT       = 4'd0,
		PH_CONFIRM    = 4'd1,
		PH_WAIT       = 4'd2,
		PH_ENTRY_FULL = 4'd3,
		PH_ENTRY_LOW  = 4'd4,
		PH_ADVANCE    = 4'd5,
		PH_SETTLE     = 4'd6,
		PH_ROWCONF    = 4'd7,
		PH_EXIT       = 4'd8,
		PH_DONE       = 4'd9
	} phase_t;

	logic [CFG_W-1:0] tap_max_q, entry_full_q, entry_low_q, advance_q;
	logic [CFG_W-1:0] settle_q, row_q, exit_q;

	phase_t          phase_q, phase_e, phase_n;
	logic [31:0]     entered_q, entered_n;
	logic [31:0]     up_time_q, down_time_q, right_time_q;
	logic [31:0]     up_time_n, down_time_n, right_time_n;
	logic [2:0]      prev_q, prev_e, dirs, rising, falling;
	logic [RowW-1:0] cursor_q, cursor_e, cursor_n;
	logic [3:0]      cur_opt_q, cur_opt_e, cur_opt_n;
	logic [PrW-1:0]  prog_q, prog_e, prog_n, prog_inc;
	logic [3:0]      pulses_q, pulses_n;
	logic [3:0]      opts_q [ROWS];
	logic [RowW-1:0] rd_idx;
	logic [3:0]      rd_opt, cnt, opt_up, opt_dn, pulses_dec;
	logic            opt_we;
	logic [31:0]     elapsed;
	logic [11:0]     throttle;
	logic            up_tap, down_tap, right_tap;

	// Bit 0 is up, bit 1 is down, bit 2 is right.
	assign dirs = {smp.raw_x > STICK_HIGH, smp.raw_y < STICK_LOW, smp.raw_y > STICK_HIGH};

	assign phase_e   = smp.restart ? PH_EDIT : phase_q;
	assign cursor_e  = smp.restart ? '0 : cursor_q;
	assign cur_opt_e = smp.restart ? 4'd0 : cur_opt_q;
	assign prog_e    = smp.restart ? '0 : prog_q;
	assign prev_e    = smp.restart ? 3'b000 : prev_q;

	assign rising  = dirs & ~prev_e;
	assign falling = prev_e & ~dirs;
	assign elapsed = smp.time_ms - entered_q;
	assign prog_inc = prog_e + PrW'(1);
	assign pulses_dec = pulses_q - 4'd1;

	assign up_tap    = falling[0] && ((smp.time_ms - up_time_q) < {16'd0, tap_max_q});
	assign down_tap  = falling[1] && ((smp.time_ms - down_time_q) < {16'd0, tap_max_q});
	assign right_tap = falling[2] && ((smp.time_ms - right_time_q) < {16'd0, tap_max_q});

	assign cnt = option_count(4'(cursor_e));
	assign opt_up = !up_tap ? cur_opt_e :
		(({1'b0, cur_opt_e} + 5'd1) < {1'b0, cnt}) ? cur_opt_e + 4'd1 : 4'd0;
	assign opt_dn = !down_tap ? opt_up : (opt_up != 4'd0) ? opt_up - 4'd1 : cnt - 4'd1;

	// Only one row is ever read for programming: row zero on entry, else the next row.
	assign rd_idx = (phase_e == PH_ENTRY_LOW) ? '0 : prog_inc[RowW-1:0];
	assign rd_opt = opts_q[rd_idx];

	always_comb begin
		phase_n = phase_e;
		entered_n = entered_q;
		up_time_n = up_time_q;
		down_time_n = down_time_q;
		right_time_n = right_time_q;
		cursor_n = cursor_e;
		cur_opt_n = cur_opt_e;
		prog_n = prog_e;
		pulses_n = pulses_q;
		opt_we = 1'b0;
		throttle = THR_NEUTRAL;
		case (phase_e)
			PH_EDIT: begin
				if (rising[0]) up_time_n = smp.time_ms;
				if (rising[1]) down_time_n = smp.time_ms;
				if (rising[2]) right_time_n = smp.time_ms;
				opt_we = 1'b1;
				cur_opt_n = opt_dn;
				if (right_tap) begin
					if (cursor_e < RowW'(ROWS - 1)) begin
						// Rows past the cursor are untouched since the last clear.
						cursor_n = cursor_e + RowW'(1);
						cur_opt_n = 4'd0;
					end else begin
						phase_n = PH_CONFIRM;
						entered_n = smp.time_ms;
					end
				end
			end
			PH_CONFIRM: begin
				if (rising[0]) begin
					phase_n = PH_WAIT;
					entered_n = smp.time_ms;
				end
			end
			PH_WAIT: begin
				if (rising[0]) begin
					phase_n = PH_ENTRY_FULL;
					entered_n = smp.time_ms;
				end
			end
			PH_ENTRY_FULL: begin
				throttle = THR_FULL;
				if (elapsed >= {16'd0, entry_full_q}) begin
					phase_n = PH_ENTRY_LOW;
					entered_n = smp.time_ms;
				end
			end
			PH_ENTRY_LOW: begin
				throttle = THR_ZERO;
				if (elapsed >= {16'd0, entry_low_q}) begin
					prog_n = '0;
					pulses_n = rd_opt;
					phase_n = (rd_opt != 4'd0) ? PH_ADVANCE : PH_ROWCONF;
					entered_n = smp.time_ms;
				end
			end
			PH_ADVANCE: begin
				throttle = THR_FULL;
				if (elapsed >= {16'd0, advance_q}) begin
					pulses_n = pulses_dec;
					phase_n = (pulses_dec != 4'd0) ? PH_ADVANCE : PH_SETTLE;
					entered_n = smp.time_ms;
				end
			end
			PH_SETTLE: begin
				throttle = THR_ZERO;
				if (elapsed >= {16'd0, settle_q}) begin
					phase_n = PH_ROWCONF;
					entered_n = smp.time_ms;
				end
			end
			PH_ROWCONF: begin
				throttle = THR_ZERO;
				if (elapsed >= {16'd0, row_q}) begin
					prog_n = prog_inc;
					entered_n = smp.time_ms;
					if (prog_inc >= PrW'(ROWS)) begin
						phase_n = PH_EXIT;
					end else begin
						pulses_n = rd_opt;
						phase_n = (rd_opt != 4'd0) ? PH_ADVANCE : PH_ROWCONF;
					end
				end
			end
			PH_EXIT: begin
				throttle = THR_FULL;
				if (elapsed >= {16'd0, exit_q}) phase_n = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_max_q <= 16'd500;
			entry_full_q <= 16'd5000;
			entry_low_q <= 16'd3000;
			advance_q <= 16'd500;
			settle_q <= 16'd500;
			row_q <= 16'd3000;
			exit_q <= 16'd3000;
			phase_q <= PH_EDIT;
			entered_q <= '0;
			up_time_q <= '0;
			down_time_q <= '0;
			right_time_q <= '0;
			prev_q <= '0;
			cursor_q <= '0;
			cur_opt_q <= '0;
			prog_q <= '0;
			pulses_q <= '0;
			for (int i = 0; i < ROWS; i++) opts_q[i] <= '0;
		end else begin
			if (cfg.we) begin
				case (cfg.idx)
					CFG_TAP_MAX: tap_max_q <= cfg.data;
					CFG_ENTRY_FULL: entry_full_q <= cfg.data;
					CFG_ENTRY_LOW: entry_low_q <= cfg.data;
					CFG_ADVANCE: advance_q <= cfg.data;
					CFG_SETTLE: settle_q <= cfg.data;
					CFG_ROW: row_q <= cfg.data;
					CFG_EXIT: exit_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (step) begin
				phase_q <= phase_n;
				entered_q <= entered_n;
				up_time_q <= up_time_n;
				down_time_q <= down_time_n;
				right_time_q <= right_time_n;
				prev_q <= dirs;
				cursor_q <= cursor_n;
				cur_opt_q <= cur_opt_n;
				prog_q <= prog_n;
				pulses_q <= pulses_n;
				for (int i = 0; i < ROWS; i++) begin
					if (opt_we && (RowW'(i) == cursor_e)) opts_q[i] <= opt_dn;
					else if (smp.restart) opts_q[i] <= '0;
				end
			end
		end
	end

	always_comb begin
		cmd.steer_out = STEER_CENTER;
		cmd.throttle_out = throttle;
		cmd.phase = phase_n;
		cmd.edit_row = 4'(cursor_n);
		cmd.edit_option = cur_opt_n;
		cmd.prog_row = 4'(prog_n);
		cmd.complete = (phase_n == PH_DONE);
	end

endmodule

@@ hw/rtl/esc_stick_programming_sequencer_top.sv @@
// Top level of the ESC stick-programming sequencer: sample register, command register
// and handshakes around the sequencer core. Depends on esc_sps_pkg and esc_sps_core.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  sample  (esc_sps_pkg::sample_t)
//   command   out        cmd_valid / cmd_stall        cmd     (esc_sps_pkg::command_t)
//   config    in         cfg_we                       cfg_idx, cfg_data
//
// A sample waits in the sample register while the core logic works out its command,
// which is then registered in the command register, and cmd_valid rises once it is
// there. One sample is accepted per cycle while sample_stall is low.
// Reset returns all state and configuration to defaults; no clearing pass is needed.
// When the command register is held by cmd_stall, the sample register holds too and
// sample_stall rises while it is occupied.
module esc_stick_programming_sequencer_top #(
	parameter int unsigned ROWS = esc_sps_pkg::ROWS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  esc_sps_pkg::sample_t                 sample,
	output logic                                 cmd_valid,
	input  logic                                 cmd_stall,
	output esc_sps_pkg::command_t                cmd,
	input  logic                                 cfg_we,
	input  logic [esc_sps_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [esc_sps_pkg::CFG_W-1:0]        cfg_data
);
	import esc_sps_pkg::*;

	logic     smp_valid_s1;
	sample_t  smp_s1;
	logic     cmd_valid_q;
	command_t cmd_q;
	command_t core_cmd;
	cfg_wr_t  cfg;
	logic     advance;
	logic     load;

	assign advance = !cmd_valid_q || !cmd_stall;
	assign sample_stall = smp_valid_s1 && !advance;
	assign load = sample_valid && !sample_stall;
	assign cfg = '{we: cfg_we, idx: cfg_idx, data: cfg_data};

	esc_sps_core #(
		.ROWS(ROWS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(smp_valid_s1 && advance),
		.smp(smp_s1),
		.cfg(cfg),
		.cmd(core_cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_s1 <= 1'b0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (load) begin
				smp_valid_s1 <= 1'b1;
			end else if (advance) begin
				smp_valid_s1 <= 1'b0;
			end
			if (advance) cmd_valid_q <= smp_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) smp_s1 <= sample;
		if (advance && smp_valid_s1) cmd_q <= core_cmd;
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd = cmd_q;

endmodule

@@ tb/sv/esc_stick_programming_sequencer_top_test.sv @@
// Self-checking testbench for the ESC stick-programming sequencer top level.
// Drives joystick samples through editing and timed programming runs and checks every command.
// Depends on esc_sps_pkg and esc_stick_programming_sequencer_top.
module esc_stick_programming_sequencer_top_test;
	import esc_sps_pkg::*;

	localparam int unsigned ROWS = ROWS_DEFAULT;

	localparam logic [3:0] PH_EDIT       = 4'd0;
	localparam logic [3:0] PH_CONFIRM    = 4'd1;
	localparam logic [3:0] PH_WAIT       = 4'd2;
	localparam logic [3:0] PH_ENTRY_FULL = 4'd3;
	localparam logic [3:0] PH_ENTRY_LOW  = 4'd4;
	localparam logic [3:0] PH_ADVANCE    = 4'd5;
	localparam logic [3:0] PH_SETTLE     = 4'd6;
	localparam logic [3:0] PH_ROWCONF    = 4'd7;
	localparam logic [3:0] PH_EXIT       = 4'd8;
	localparam logic [3:0] PH_DONE       = 4'd9;

	localparam logic [2:0] DIR_UP    = 3'b001;
	localparam logic [2:0] DIR_DOWN  = 3'b010;
	localparam logic [2:0] DIR_RIGHT = 3'b100;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	localparam logic [15:0][3:0] OPTION_COUNTS = {4'd10, 4'd10, 4'd10, 4'd10, 4'd6, 4'd7,
		4'd8, 4'd10, 4'd10, 4'd10, 4'd8, 4'd10, 4'd10, 4'd10, 4'd2, 4'd4};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic cmd_valid;
	logic cmd_stall = 1'b0;
	command_t cmd;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [15:0] timing [7] = '{16'd500, 16'd5000, 16'd3000, 16'd500, 16'd500, 16'd3000,
		16'd3000};
	logic [3:0] seq_phase = PH_EDIT;
	logic [31:0] phase_since = '0;
	logic [31:0] up_since = '0;
	logic [31:0] down_since = '0;
	logic [31:0] right_since = '0;
	logic [2:0] held_dirs = '0;
	logic [3:0] cursor = '0;
	logic [3:0] options [16];
	logic [4:0] prog_row_at = '0;
	logic [3:0] pulses = '0;

	sample_t stick_queue [$];
	command_t due_commands [$];
	command_t want;
	logic [31:0] stick_ms = '0;
	bit calm = 1'b0;
	int unsigned idle_odds = 6;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned samples_sent = 0;
	int unsigned cmds_seen = 0;
	int unsigned mismatches = 0;
	int unsigned runs_done = 0;
	int unsigned rows_done = 0;
	int unsigned settings_run = 1;

	esc_stick_programming_sequencer_top #(.ROWS(ROWS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void enter_phase(input logic [3:0] p, input logic [31:0] now);
		seq_phase = p;
		phase_since = now;
	endfunction

	function automatic void begin_row(input logic [31:0] now);
		pulses = options[prog_row_at[3:0]];
		enter_phase(pulses != 0 ? PH_ADVANCE : PH_ROWCONF, now);
	endfunction

	function automatic command_t next_command(input sample_t s);
		command_t c;
		logic [2:0] dirs, rise, fall;
		logic [31:0] elapsed, up_held, down_held, right_held, tap_lim;
		logic [3:0] r, cnt;
		logic [11:0] thr;
		thr = THR_NEUTRAL;
		if (s.restart) begin
			seq_phase = PH_EDIT;
			cursor = '0;
			prog_row_at = '0;
			foreach (options[i]) options[i] = '0;
			held_dirs = '0;
		end
		elapsed = s.time_ms - phase_since;
		dirs = {s.raw_x > STICK_HIGH, s.raw_y < STICK_LOW, s.raw_y > STICK_HIGH};
		case (seq_phase)
			PH_EDIT: begin
				r = cursor;
				cnt = OPTION_COUNTS[r];
				rise = dirs & ~held_dirs;
				fall = held_dirs & ~dirs;
				tap_lim = {16'd0, timing[CFG_TAP_MAX]};
				if ((rise & DIR_UP) != 0) up_since = s.time_ms;
				if ((rise & DIR_DOWN) != 0) down_since = s.time_ms;
				if ((rise & DIR_RIGHT) != 0) right_since = s.time_ms;
				up_held = s.time_ms - up_since;
				down_held = s.time_ms - down_since;
				right_held = s.time_ms - right_since;
				if ((fall & DIR_UP) != 0 && up_held < tap_lim)
					options[r] = (options[r] + 4'd1 < cnt) ? options[r] + 4'd1 : 4'd0;
				if ((fall & DIR_DOWN) != 0 && down_held < tap_lim)
					options[r] = (options[r] != 0) ? options[r] - 4'd1 : cnt - 4'd1;
				if ((fall & DIR_RIGHT) != 0 && right_held < tap_lim) begin
					if (cursor < ROWS - 1) cursor = cursor + 4'd1;
					else enter_phase(PH_CONFIRM, s.time_ms);
				end
			end
			PH_CONFIRM: begin
				if ((dirs & ~held_dirs & DIR_UP) != 0) enter_phase(PH_WAIT, s.time_ms);
			end
			PH_WAIT: begin
				if ((dirs & ~held_dirs & DIR_UP) != 0) enter_phase(PH_ENTRY_FULL, s.time_ms);
			end
			PH_ENTRY_FULL: begin
				thr = THR_FULL;
				if (elapsed >= {16'd0, timing[CFG_ENTRY_FULL]})
					enter_phase(PH_ENTRY_LOW, s.time_ms);
			end
			PH_ENTRY_LOW: begin
				thr = THR_ZERO;
				if (elapsed >= {16'd0, timing[CFG_ENTRY_LOW]}) begin
					prog_row_at = '0;
					begin_row(s.time_ms);
				end
			end
			PH_ADVANCE: begin
				thr = THR_FULL;
				if (elapsed >= {16'd0, timing[CFG_ADVANCE]}) begin
					pulses = pulses - 4'd1;
					enter_phase(pulses != 0 ? PH_ADVANCE : PH_SETTLE, s.time_ms);
				end
			end
			PH_SETTLE: begin
				thr = THR_ZERO;
				if (elapsed >= {16'd0, timing[CFG_SETTLE]}) enter_phase(PH_ROWCONF, s.time_ms);
			end
			PH_ROWCONF: begin
				thr = THR_ZERO;
				if (elapsed >= {16'd0, timing[CFG_ROW]}) begin
					prog_row_at = prog_row_at + 5'd1;
					rows_done++;
					if (prog_row_at >= ROWS) enter_phase(PH_EXIT, s.time_ms);
					else begin_row(s.time_ms);
				end
			end
			PH_EXIT: begin
				thr = THR_FULL;
				if (elapsed >= {16'd0, timing[CFG_EXIT]}) begin
					seq_phase = PH_DONE;
					runs_done++;
				end
			end
			default: begin
			end
		endcase
		held_dirs = dirs;
		c.steer_out = STEER_CENTER;
		c.throttle_out = thr;
		c.phase = seq_phase;
		c.edit_row = cursor;
		c.edit_option = options[cursor];
		c.prog_row = prog_row_at[3:0];
		c.complete = (seq_phase == PH_DONE);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				due_commands.push_back(next_command(sample));
				samples_sent++;
			end
			if (!sample_valid || !sample_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					sample_valid <= 1'b0;
				end else if (stick_queue.size() != 0) begin
					sample <= stick_queue.pop_front();
					sample_valid <= 1'b1;
					if (!calm && $urandom_range(0, idle_odds) == 0) gap_left = $urandom_range(1, 17);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_stall <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				cmds_seen++;
				if (due_commands.size() == 0) begin
					if (mismatches < 10) $display("Command %0d arrived with no sample waiting", cmds_seen);
					mismatches++;
				end else begin
					want = due_commands.pop_front();
					if (cmd !== want) begin
						if (mismatches < 10) begin
							$display("Command %0d expected: steer %0d thr %0d phase %0d row %0d option %0d",
								cmds_seen, want.steer_out, want.throttle_out, want.phase, want.edit_row,
								want.edit_option);
							$display("    prog %0d done %0d; got: steer %0d thr %0d phase %0d row %0d",
								want.prog_row, want.complete, cmd.steer_out, cmd.throttle_out, cmd.phase,
								cmd.edit_row);
							$display("    option %0d prog %0d done %0d", cmd.edit_option, cmd.prog_row,
								cmd.complete);
						end
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				cmd_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, idle_odds) == 0) begin
				stall_left = $urandom_range(0, 16);
				cmd_stall <= 1'b1;
			end else begin
				cmd_stall <= 1'b0;
			end
		end
	end

	function automatic logic [11:0] rest_x();
		return 12'($urandom_range(0, 3500));
	endfunction

	function automatic logic [11:0] rest_y();
		return 12'($urandom_range(500, 3500));
	endfunction

	function automatic int unsigned tap_hold();
		int unsigned lim;
		lim = {16'd0, timing[CFG_TAP_MAX]};
		if (lim == 0) return $urandom_range(0, 200);
		case ($urandom_range(0, 9))
			0: return lim;
			1: return lim - 1;
			default: return $urandom_range(0, lim - 1);
		endcase
	endfunction

	function automatic int unsigned pick_delay(input int unsigned span);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return span;
			2: return (span == 0) ? 0 : span - 1;
			3: return $urandom_range(0, span);
			default: return span + $urandom_range(0, span / 2 + 1);
		endcase
	endfunction

	task automatic push_sample(input logic [11:0] x, input logic [11:0] y,
		input int unsigned dt, input logic rst);
		sample_t s;
		stick_ms = stick_ms + dt;
		s.raw_x = x;
		s.raw_y = y;
		s.time_ms = stick_ms;
		s.restart = rst;
		stick_queue.push_back(s);
	endtask

	task automatic push_noise();
		sample_t s;
		s.raw_x = 12'($urandom);
		s.raw_y = 12'($urandom);
		s.time_ms = $urandom;
		s.restart = ($urandom_range(0, 3) == 0);
		stick_ms = s.time_ms;
		stick_queue.push_back(s);
	endtask

	task automatic push_press(input logic [2:0] dirs, input int unsigned hold);
		logic [11:0] x, y;
		int unsigned part;
		x = ((dirs & DIR_RIGHT) != 0) ? 12'($urandom_range(3501, 4095)) : rest_x();
		if ((dirs & DIR_UP) != 0) y = 12'($urandom_range(3501, 4095));
		else if ((dirs & DIR_DOWN) != 0) y = 12'($urandom_range(0, 499));
		else y = rest_y();
		push_sample(x, y, $urandom_range(0, 2000), 1'b0);
		if ($urandom_range(0, 5) == 0) begin
			part = $urandom_range(0, hold);
			push_sample(x, y, part, 1'b0);
			hold = hold - part;
		end
		push_sample(rest_x(), rest_y(), hold, 1'b0);
	endtask

	task automatic push_session();
		int unsigned presses, stay, span, lim;
		span = 0;
		lim = {16'd0, timing[CFG_TAP_MAX]};
		for (int i = CFG_ENTRY_FULL; i <= CFG_EXIT; i++)
			if ({16'd0, timing[i]} > span) span = {16'd0, timing[i]};
		if ($urandom_range(0, 3) == 0) stick_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		push_sample(rest_x(), rest_y(), $urandom_range(0, 2000), $urandom_range(0, 3) != 0);
		for (int r = 0; r < ROWS; r++) begin
			presses = $urandom_range(0, 6);
			repeat (presses) begin
				case ($urandom_range(0, 11))
					0: push_noise();
					1: push_press(DIR_UP, lim + $urandom_range(0, 1500));
					2, 3, 4, 5, 6: push_press(DIR_UP, tap_hold());
					default: push_press(DIR_DOWN, tap_hold());
				endcase
			end
			push_press(($urandom_range(0, 4) == 0) ? (DIR_RIGHT | DIR_DOWN) : DIR_RIGHT,
				(lim == 0) ? 0 : $urandom_range(0, lim - 1));
		end
		push_press(DIR_UP, $urandom_range(0, 3000));
		push_press(DIR_UP, $urandom_range(0, 3000));
		stay = $urandom_range(30, 110);
		repeat (stay) begin
			if ($urandom_range(0, 7) == 0)
				push_sample(12'($urandom), 12'($urandom), pick_delay(span), 1'b0);
			else push_sample(rest_x(), rest_y(), pick_delay(span), 1'b0);
		end
	endtask

	task automatic queue_sessions(input int unsigned target);
		@(negedge clk);
		while (stick_queue.size() < target) begin
			push_session();
			repeat ($urandom_range(0, 12)) push_noise();
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (stick_queue.size() != 0 || sample_valid || due_commands.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic load_timing(input bit stray);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= i[CFG_IDX_W-1:0];
			cfg_data <= timing[i];
			@(posedge clk);
		end
		if (stray) begin
			cfg_idx <= CFG_UNUSED;
			cfg_data <= 16'($urandom_range(0, 65535));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	initial begin
		foreach (options[i]) options[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Thresholds, tap length at the limit, wrap of the option table and same-sample taps.
		push_sample(0, 2048, 10, 1'b0);
		push_sample(2048, 3501, 100, 1'b0);
		push_sample(2048, 3500, 499, 1'b0);
		push_sample(2048, 499, 50, 1'b0);
		push_sample(2048, 500, 500, 1'b0);
		push_sample(2048, 0, 20, 1'b0);
		push_sample(2048, 2048, 10, 1'b0);
		push_sample(2048, 0, 10, 1'b0);
		push_sample(2048, 2048, 10, 1'b0);
		push_sample(2048, 4095, 10, 1'b0);
		push_sample(2048, 0, 10, 1'b0);
		push_sample(3501, 2048, 10, 1'b0);
		push_sample(3500, 4095, 10, 1'b0);
		push_sample(4095, 4095, 10, 1'b0);
		push_sample(2048, 2048, 10, 1'b0);
		// Restart with sticks held just before the timestamp wraps, released after it.
		stick_ms = 32'hFFFF_FF00;
		push_sample(4095, 4095, 0, 1'b1);
		push_sample(2048, 2048, 300, 1'b0);
		push_sample(4095, 0, 0, 1'b0);
		push_sample(0, 4095, 0, 1'b0);
		push_sample(2048, 2048, 499, 1'b0);
		queue_sessions(200);

		wait_idle();
		idle_odds = 3;
		foreach (timing[i]) timing[i] = 16'd0;
		load_timing(1'b0);
		queue_sessions(60);

		wait_idle();
		idle_odds = 12;
		foreach (timing[i]) timing[i] = 16'd0;
		timing[CFG_TAP_MAX] = 16'hFFFF;
		load_timing(1'b1);
		queue_sessions(150);

		wait_idle();
		idle_odds = 40;
		foreach (timing[i]) timing[i] = 16'hFFFF;
		load_timing(1'b0);
		queue_sessions(150);

		wait_idle();
		idle_odds = 8;
		foreach (timing[i]) timing[i] = 16'($urandom_range(1, 60));
		timing[CFG_TAP_MAX] = 16'($urandom_range(2, 200));
		load_timing(1'b1);
		queue_sessions(180);

		wait_idle();
		calm = 1'b1;
		foreach (timing[i]) timing[i] = 16'($urandom_range(0, 4000));
		timing[CFG_TAP_MAX] = 16'($urandom_range(50, 800));
		load_timing(1'b0);
		queue_sessions(150);

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Sent %0d stick samples under %0d timing settings, checked %0d commands.",
			samples_sent, settings_run, cmds_seen);
		$display("Programming ran to the end %0d times over %0d confirmed rows; %0d mismatches.",
			runs_done, rows_done, mismatches);
		if (mismatches == 0 && due_commands.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/esc_sps_pkg.sv
hw/rtl/esc_sps_core.sv
hw/rtl/esc_stick_programming_sequencer_top.sv
tb/sv/esc_stick_programming_sequencer_top_test.sv
